>>> hdl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; the other files, except bba_ram.sv, refer to it by scoped names.

package bba_pkg;

	// Default geometry of the bitmap
	localparam int DEF_BITS_PER_BITMAP_BLOCK = 4096;
	localparam int DEF_BITMAP_BLOCKS         = 1;
	localparam int DEF_WORD_BITS             = 64;

	// Field widths of the request, response and register
	localparam int BN_W = 12;
	localparam int BC_W = 13;
	localparam int ST_W = 2;

	localparam int              BYTE_BITS = 8;
	localparam logic [7:0]      FULL_BYTE = 8'hFF;
	localparam logic [BN_W-1:0] IDX_MAX   = 12'hFFF;
	localparam logic [BC_W-1:0] BC_RESET  = 13'd4096;

	// Request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Response status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK           = 2'd0,
		ST_NO_FREE      = 2'd1,
		ST_INVALID      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	// Flags from the shared word/byte/bit probe
	typedef struct packed {
		logic       word_full;
		logic       byte_full;
		logic [2:0] low_clear;
		logic       bit_set;
	} probe_t;

endpackage

>>> hdl/bba_if.sv
// Valid/ready channel interfaces of the bitmap block allocator.
// Depends on bba_pkg for field widths.

interface bba_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [bba_pkg::BN_W-1:0]  block_number;

	modport source (output valid, mode, block_number, input ready);
	modport sink   (input valid, mode, block_number, output ready);
endinterface

interface bba_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [bba_pkg::ST_W-1:0]  status;
	logic [bba_pkg::BN_W-1:0]  allocated_block;

	modport source (output valid, status, allocated_block, input ready);
	modport sink   (input valid, status, allocated_block, output ready);
endinterface

interface bba_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bba_pkg::BC_W-1:0]  block_count;

	modport source (output valid, block_count, input ready);
	modport sink   (input valid, block_count, output ready);
endinterface

>>> hdl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/bba_probe.sv
// Shared test unit: word-full check, byte select with lowest-clear search, bit test.
// Depends on bba_pkg for the probe_t result struct.

module bba_probe #(
	parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS,
	localparam int BPW = WORD_BITS / bba_pkg::BYTE_BITS,
	localparam int BW  = (BPW > 1) ? $clog2(BPW) : 1,
	localparam int OW  = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [BW-1:0]        byte_sel,
	input  logic [OW-1:0]        bit_sel,
	output bba_pkg::probe_t      res
);

	logic [7:0] sel_byte;

	// Pick the byte and find its lowest clear bit
	always_comb begin
		sel_byte = word[byte_sel*bba_pkg::BYTE_BITS +: bba_pkg::BYTE_BITS];
		res.word_full = &word;
		res.byte_full = (sel_byte == bba_pkg::FULL_BYTE);
		res.bit_set   = word[bit_sel];
		res.low_clear = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!sel_byte[i]) begin
				res.low_clear = 3'(i);
			end
		end
	end

endmodule

>>> hdl/bitmap_block_allocator_core.sv
// Allocate: first-fit scan, one bitmap word per cycle, then one byte per cycle in the
// first non-full word, then the result is posted. Free: the word index is found by a
// reciprocal multiply, the word is read, and the bit is checked and cleared if set; an
// out-of-range index goes straight to posting. A stalled response adds its wait; one
// request at a time, and the next transfer is taken once the result is posted.
// Reset (arst_n low) clears per-word valid bits, so the whole bitmap reads free at once.
// block_count resets to 4096; the user writes it through cfg only while the block is idle (not enforced here).

module bitmap_block_allocator_core #(
	parameter int BITS_PER_BITMAP_BLOCK = bba_pkg::DEF_BITS_PER_BITMAP_BLOCK,
	parameter int BITMAP_BLOCKS         = bba_pkg::DEF_BITMAP_BLOCKS,
	parameter int WORD_BITS             = bba_pkg::DEF_WORD_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp,
	bba_cfg_if.sink   cfg
);

	localparam int TOTAL_BITS = BITMAP_BLOCKS * BITS_PER_BITMAP_BLOCK;
	localparam int NUM_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BPW        = WORD_BITS / bba_pkg::BYTE_BITS;
	localparam int BW         = (BPW > 1) ? $clog2(BPW) : 1;
	localparam int OW         = $clog2(WORD_BITS);
	localparam int IW         = $clog2(TOTAL_BITS + 1);
	localparam int CW         = (IW > bba_pkg::BC_W) ? IW : bba_pkg::BC_W;
	localparam int LAST_BITS  = TOTAL_BITS - (NUM_WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] PAD_MASK =
		~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
	localparam logic [WA-1:0] LAST_WORD = WA'(NUM_WORDS - 1);
	// Word of a block number by multiplying with a rounded-up reciprocal
	localparam int SH    = bba_pkg::BN_W + OW;
	localparam int RECIP = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int PW    = (SH + WA > bba_pkg::BN_W + 14) ? SH + WA : bba_pkg::BN_W + 14;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_BYTE, S_FR_DIV, S_FR_RD, S_FR_CHK, S_POST
	} state_t;

	state_t                     state_q;
	logic [WA-1:0]              word_q;
	logic [IW-1:0]              base_q;
	logic [BW-1:0]              byte_q;
	logic [OW-1:0]              off_q;
	logic [bba_pkg::BN_W-1:0]   bn_q;
	logic [WORD_BITS-1:0]       word_data_q;
	logic [NUM_WORDS-1:0]       valid_q;
	logic [bba_pkg::BC_W-1:0]   block_count_q;
	bba_pkg::status_t           res_status_q;
	logic [bba_pkg::BN_W-1:0]   res_alloc_q;
	logic                       rsp_valid_q;
	bba_pkg::status_t           status_q;
	logic [bba_pkg::BN_W-1:0]   alloc_q;

	logic                       ram_we;
	logic [WA-1:0]              ram_waddr;
	logic [WORD_BITS-1:0]       ram_wdata;
	logic                       ram_re;
	logic [WA-1:0]              ram_raddr;
	logic [WORD_BITS-1:0]       ram_rdata;
	logic [WORD_BITS-1:0]       mword;
	logic [WORD_BITS-1:0]       probe_word;
	bba_pkg::probe_t            probe;
	logic [OW-1:0]              alloc_off;
	logic [IW-1:0]              cand;
	logic                       too_far;
	logic                       free_range_bad;
	logic [PW-1:0]              prod;
	logic [bba_pkg::BN_W:0]     off_full;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.allocated_block = alloc_q;

	// Hold the block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= bba_pkg::BC_RESET;
		end else if (cfg.valid) begin
			block_count_q <= cfg.block_count;
		end
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Mask unwritten words to free and padding bits to taken
	always_comb begin
		mword = ram_rdata & {WORD_BITS{valid_q[word_q]}};
		if (word_q == LAST_WORD) begin
			mword = mword | PAD_MASK;
		end
		probe_word = (state_q == S_BYTE) ? word_data_q : mword;
	end

	bba_probe #(
		.WORD_BITS (WORD_BITS)
	) u_probe (
		.word     (probe_word),
		.byte_sel (byte_q),
		.bit_sel  (off_q),
		.res      (probe)
	);

	// Candidate index, range checks and block-number division
	always_comb begin
		alloc_off = OW'({byte_q, 3'b000}) + OW'(probe.low_clear);
		cand = base_q + IW'({byte_q, 3'b000}) + IW'(probe.low_clear);
		too_far = (CW'(cand) >= CW'(block_count_q)) || (CW'(cand) > CW'(bba_pkg::IDX_MAX));
		free_range_bad = ({1'b0, req.block_number} >= block_count_q) ||
			(32'(req.block_number) >= 32'(TOTAL_BITS));
		prod = PW'(bn_q) * PW'(RECIP);
		off_full = (bba_pkg::BN_W + 1)'(bn_q) -
			(bba_pkg::BN_W + 1)'(int'(word_q) * WORD_BITS);
	end

	// Drive the RAM read and write ports from the sequencer state
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = word_q;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = word_data_q | (WORD_BITS'(1) << alloc_off);
		unique case (state_q)
			S_IDLE: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = (word_q == LAST_WORD) ? '0 : word_q + WA'(1);
			end
			S_FR_RD: begin
				ram_re = 1'b1;
			end
			S_BYTE: begin
				ram_we = !probe.byte_full && !too_far;
			end
			S_FR_CHK: begin
				ram_we    = probe.bit_set;
				ram_wdata = mword & ~(WORD_BITS'(1) << off_q);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Sequencer: scan words, then bytes, or locate and clear a bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			word_q       <= '0;
			base_q       <= '0;
			byte_q       <= '0;
			off_q        <= '0;
			bn_q         <= '0;
			word_data_q  <= '0;
			valid_q      <= '0;
			res_status_q <= bba_pkg::ST_OK;
			res_alloc_q  <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= bba_pkg::ST_OK;
			alloc_q      <= '0;
		end else begin
			if (ram_we) begin
				valid_q[word_q] <= 1'b1;
			end
			if (rsp.ready && state_q != S_POST) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						bn_q        <= req.block_number;
						word_q      <= '0;
						base_q      <= '0;
						res_alloc_q <= '0;
						if (req.mode == bba_pkg::MODE_ALLOC) begin
							state_q <= S_SCAN;
						end else if (free_range_bad) begin
							res_status_q <= bba_pkg::ST_INVALID;
							state_q      <= S_POST;
						end else begin
							state_q <= S_FR_DIV;
						end
					end
				end
				S_SCAN: begin
					if (!probe.word_full) begin
						word_data_q <= mword;
						byte_q      <= '0;
						state_q     <= S_BYTE;
					end else if (word_q == LAST_WORD) begin
						res_status_q <= bba_pkg::ST_NO_FREE;
						state_q      <= S_POST;
					end else begin
						word_q <= word_q + WA'(1);
						base_q <= base_q + IW'(WORD_BITS);
					end
				end
				S_BYTE: begin
					if (probe.byte_full) begin
						byte_q <= byte_q + BW'(1);
					end else begin
						if (too_far) begin
							res_status_q <= bba_pkg::ST_NO_FREE;
						end else begin
							res_status_q <= bba_pkg::ST_OK;
							res_alloc_q  <= bba_pkg::BN_W'(cand);
						end
						state_q <= S_POST;
					end
				end
				S_FR_DIV: begin
					word_q  <= prod[SH +: WA];
					state_q <= S_FR_RD;
				end
				S_FR_RD: begin
					off_q   <= off_full[OW-1:0];
					state_q <= S_FR_CHK;
				end
				S_FR_CHK: begin
					res_status_q <= probe.bit_set ? bba_pkg::ST_OK : bba_pkg::ST_ALREADY_FREE;
					state_q      <= S_POST;
				end
				S_POST: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status_q;
						alloc_q     <= res_alloc_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Only a successful allocate returns a nonzero index
	a_alloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != bba_pkg::ST_OK) |-> (rsp.allocated_block == '0))
		else $error("nonzero index on a failed or free response");

	// Bitmap writes come only from the byte pick or the free check
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_BYTE || state_q == S_FR_CHK))
		else $error("bitmap write outside a write state");

	// Word scan stays inside the bitmap
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (word_q <= LAST_WORD))
		else $error("scan word beyond the bitmap");

	// A scan starts at word zero with a zero base index
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) == S_IDLE) |-> (word_q == '0 && base_q == '0))
		else $error("scan did not start at word zero");

	// A posted result reaches the response register once it is free
	a_post_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && (!rsp_valid_q || rsp.ready)) |=> rsp.valid)
		else $error("posted result not presented");

endmodule

>>> tb/bitmap_block_allocator_core_tb.sv
// Self-checking testbench for bitmap_block_allocator_core: first-fit allocate and free.
// Depends on bba_pkg, the channel interfaces in bba_if.sv and the allocator core.

module bitmap_block_allocator_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BN_W        = bba_pkg::BN_W;
	localparam int BC_W        = bba_pkg::BC_W;
	localparam int MAP_BITS    = bba_pkg::DEF_BITS_PER_BITMAP_BLOCK * bba_pkg::DEF_BITMAP_BLOCKS;
	localparam int MAP_BYTES   = MAP_BITS / bba_pkg::BYTE_BITS;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE      = 80;
	localparam int PRINT_CAP   = 40;
	localparam int FILL_COUNT  = 520;
	localparam int PHASE_ITEMS = 56;

	typedef struct {
		bba_pkg::status_t status;
		logic [BN_W-1:0]  block;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();
	bba_cfg_if cfg_ch ();

	bitmap_block_allocator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the allocator state
	bit [MAP_BITS-1:0] block_map;
	logic [BC_W-1:0]   count_limit;

	alloc_result_t pending_results[$];

	int  mismatch_count;
	int  cycle_count;
	int  request_count;
	int  cfg_writes;
	int  status_seen[4];
	bit  calm;
	int  rsp_hold_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Compute the response to one request and advance the mirrored bitmap
	function automatic alloc_result_t apply_request(input logic m, input logic [BN_W-1:0] bn);
		alloc_result_t res;
		int k;
		int b;
		int idx;
		logic [7:0] byte_val;
		res.status = bba_pkg::ST_OK;
		res.block  = '0;
		if (m == bba_pkg::MODE_ALLOC) begin
			k = 0;
			byte_val = bba_pkg::FULL_BYTE;
			while (k < MAP_BYTES) begin
				byte_val = block_map[k*bba_pkg::BYTE_BITS +: bba_pkg::BYTE_BITS];
				if (byte_val != bba_pkg::FULL_BYTE)
					break;
				k++;
			end
			if (k >= MAP_BYTES) begin
				res.status = bba_pkg::ST_NO_FREE;
			end else begin
				b = 0;
				while (b < bba_pkg::BYTE_BITS && byte_val[b])
					b++;
				idx = k * bba_pkg::BYTE_BITS + b;
				if (idx >= int'(count_limit) || idx > int'(bba_pkg::IDX_MAX)) begin
					res.status = bba_pkg::ST_NO_FREE;
				end else begin
					block_map[idx] = 1'b1;
					res.block = idx[BN_W-1:0];
				end
			end
		end else begin
			if (int'(bn) >= int'(count_limit) || int'(bn) >= MAP_BITS)
				res.status = bba_pkg::ST_INVALID;
			else if (!block_map[bn])
				res.status = bba_pkg::ST_ALREADY_FREE;
			else
				block_map[bn] = 1'b0;
		end
		return res;
	endfunction

	// Drive one request after a random gap; predict at the transfer
	task automatic send_request(input logic m, input logic [BN_W-1:0] bn);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid        <= 1'b0;
			req_ch.mode         <= 1'($urandom_range(0, 1));
			req_ch.block_number <= BN_W'($urandom_range(0, 4095));
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= m;
		req_ch.block_number <= bn;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(apply_request(m, bn));
		request_count++;
	endtask

	// Drop valid and wait until every response is back
	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_block_count(input logic [BC_W-1:0] value);
		drain_requests();
		@(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.block_count <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		count_limit = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Response ready: random stalls of varied length
	initial begin
		rsp_ch.ready  = 1'b0;
		rsp_hold_left = 0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					rsp_hold_left = pick_gap();
			end
		end
	end

	// Compare each response transfer with the oldest prediction
	always @(posedge clk) begin : check_rsp
		alloc_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected response status %0d block %0d",
					rsp_ch.status, rsp_ch.allocated_block));
			end else begin
				want = pending_results.pop_front();
				status_seen[want.status]++;
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %s", rsp_ch.status,
						want.status.name()));
				if (rsp_ch.allocated_block !== want.block)
					report_mismatch($sformatf("allocated_block %0d, want %0d",
						rsp_ch.allocated_block, want.block));
			end
		end
	end

	// Pick a block that is currently allocated, starting near a random point
	function automatic logic [BN_W-1:0] pick_owned();
		int lim;
		int start;
		int b;
		lim = (count_limit == 0 || int'(count_limit) > MAP_BITS) ? MAP_BITS : int'(count_limit);
		start = $urandom_range(0, lim - 1);
		for (int i = 0; i < MAP_BITS; i++) begin
			b = (start + i) % MAP_BITS;
			if (block_map[b])
				return b[BN_W-1:0];
		end
		return start[BN_W-1:0];
	endfunction

	// First fit from an empty map, reuse of freed blocks, double free
	task automatic test_first_fit();
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'hFFF);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'd1);
		send_request(bba_pkg::MODE_FREE, 12'd1);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'hFFF);
		send_request(bba_pkg::MODE_FREE, 12'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
	endtask

	// Block count at zero, inside the first byte and just past a byte boundary
	task automatic test_count_limits();
		write_block_count(13'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'd0);
		write_block_count(13'd4);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'd4);
		send_request(bba_pkg::MODE_FREE, 12'd3);
		write_block_count(13'd9);
		repeat (6) send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'd8);
	endtask

	// Fill every block under a raised count across several words, then free and reuse blocks at the ends and middle
	task automatic test_full_map();
		int free_bits;
		write_block_count(BC_W'(FILL_COUNT));
		free_bits = 0;
		for (int i = 0; i < FILL_COUNT; i++)
			if (!block_map[i])
				free_bits++;
		repeat (free_bits + 2)
			send_request(bba_pkg::MODE_ALLOC, BN_W'($urandom_range(0, 4095)));
		send_request(bba_pkg::MODE_FREE, BN_W'(FILL_COUNT - 1));
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_FREE, BN_W'(FILL_COUNT));
		send_request(bba_pkg::MODE_FREE, 12'd0);
		send_request(bba_pkg::MODE_FREE, 12'd256);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
		send_request(bba_pkg::MODE_ALLOC, 12'd0);
	endtask

	// Phases of mixed traffic under different block counts
	task automatic test_random_traffic();
		int alloc_pct;
		int r;
		logic [BC_W-1:0] limit;
		for (int phase = 0; phase < 14; phase++) begin
			case (phase % 7)
				0: limit = bba_pkg::BC_RESET;
				1: limit = 13'd0;
				2: limit = BC_W'($urandom_range(1, 24));
				3: limit = BC_W'($urandom_range(1, 4096));
				4: limit = BC_W'($urandom_range(25, 200));
				5: limit = 13'd4095;
				default: limit = BC_W'($urandom_range(1, 4096));
			endcase
			write_block_count(limit);
			calm = ($urandom_range(0, 3) == 0);
			alloc_pct = $urandom_range(20, 75);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < alloc_pct)
					send_request(bba_pkg::MODE_ALLOC, BN_W'($urandom_range(0, 4095)));
				else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4)
					send_request(bba_pkg::MODE_FREE, pick_owned());
				else if (r % 3 == 0)
					send_request(bba_pkg::MODE_FREE,
						count_limit[BN_W-1:0] - BN_W'($urandom_range(0, 1)));
				else
					send_request(bba_pkg::MODE_FREE, BN_W'($urandom_range(0, 4095)));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = bba_pkg::MODE_ALLOC;
		req_ch.block_number = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.block_count  = '0;
		block_map           = '0;
		count_limit         = bba_pkg::BC_RESET;
		calm                = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_fit();
		test_count_limits();
		test_full_map();
		test_random_traffic();

		drain_requests();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d requests over %0d block_count writes", request_count, cfg_writes);
		$display("status mix: ok %0d, no free %0d, invalid %0d, already free %0d, %0d mismatches",
			status_seen[bba_pkg::ST_OK], status_seen[bba_pkg::ST_NO_FREE],
			status_seen[bba_pkg::ST_INVALID], status_seen[bba_pkg::ST_ALREADY_FREE],
			mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
